/* src/cbz_pkg.sv */
// Shared types, codes and weight table for the B-spline to Bezier converter.
package cbz_pkg;

  localparam int COORD_BITS_DEF = 24;

  // Result roles
  localparam logic [1:0] ROLE_JUNC   = 2'd0;
  localparam logic [1:0] ROLE_INNER1 = 2'd1;
  localparam logic [1:0] ROLE_INNER2 = 2'd2;

  // Kinds of result point, each a weighted sum over 12
  localparam logic [2:0] KIND_E_FIRST = 3'd0;
  localparam logic [2:0] KIND_E_INNER = 3'd1;
  localparam logic [2:0] KIND_F       = 3'd2;
  localparam logic [2:0] KIND_G       = 3'd3;
  localparam logic [2:0] KIND_Z       = 3'd4;

  typedef struct packed {
    logic [3:0] w0;
    logic [3:0] w1;
    logic [3:0] w2;
  } wgt_t;

  typedef struct packed {
    logic [1:0] role;
    logic       run_last;
    logic       curve_end;
  } tag_t;

  // All weights share the denominator 12, so one rounding divider serves all.
  function automatic wgt_t kind_wgt(input logic [2:0] kind);
    wgt_t w;
    case (kind)
      KIND_E_FIRST: w = '{w0: 4'd3, w1: 4'd7, w2: 4'd2};
      KIND_E_INNER: w = '{w0: 4'd2, w1: 4'd8, w2: 4'd2};
      KIND_F:       w = '{w0: 4'd0, w1: 4'd8, w2: 4'd4};
      KIND_G:       w = '{w0: 4'd0, w1: 4'd4, w2: 4'd8};
      KIND_Z:       w = '{w0: 4'd2, w1: 4'd7, w2: 4'd3};
      default:      w = '{w0: 4'd0, w1: 4'd0, w2: 4'd0};
    endcase
    return w;
  endfunction

endpackage

/* src/cbz_coord.sv */
// One coordinate: weighted sum, then rounded division by 12, three stages.
module cbz_coord #(
  parameter int CB = cbz_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] x0,
  input  logic signed [CB-1:0] x1,
  input  logic signed [CB-1:0] x2,
  input  cbz_pkg::wgt_t        wgt,
  output logic signed [CB-1:0] q
);

  localparam int NW = CB + 4;       // signed sum of up to 12 * |x|
  localparam int MW = CB + 1;       // (|n| + 6) / 4
  localparam int K  = MW / 2;       // low half of the divide by 3
  localparam int HW = MW - K;       // high half
  localparam longint unsigned MH3_L = ((64'd1 << (HW + 1)) + 64'd2) / 64'd3;
  localparam longint unsigned MT3_L = ((64'd1 << (K + 3)) + 64'd2) / 64'd3;
  localparam logic [HW-1:0]  MH3 = MH3_L[HW-1:0];
  localparam logic [K+1:0]   MT3 = MT3_L[K+1:0];

  // stage 1: weighted sum
  logic signed [NW-1:0] e0, e1, e2, w0e, w1e, w2e, n_nxt;
  logic signed [NW-1:0] n_r;

  assign e0  = NW'(x0);
  assign e1  = NW'(x1);
  assign e2  = NW'(x2);
  assign w0e = NW'(wgt.w0);
  assign w1e = NW'(wgt.w1);
  assign w2e = NW'(wgt.w2);
  assign n_nxt = e0 * w0e + e1 * w1e + e2 * w2e;

  // stage 2: magnitude with half added, high half divided by 3
  logic              neg;
  logic [NW-1:0]     mag, mag6;
  logic [MW-1:0]     m;
  logic [2*HW-1:0]   ph;
  logic              neg_r;
  logic [HW-2:0]     qh_r;
  logic [HW-1:0]     mh_r;
  logic [K-1:0]      ml_r;

  assign neg  = n_r[NW-1];
  assign mag  = neg ? NW'(-n_r) : NW'(n_r);
  assign mag6 = mag + NW'(6);
  assign m    = mag6[MW+1:2];
  assign ph   = (2*HW)'(m[MW-1:K]) * (2*HW)'(MH3);

  // stage 3: remainder carried into low half, then sign
  logic [HW+1:0]   r3;
  logic [K+1:0]    t;
  logic [2*K+3:0]  pt;
  logic [K-1:0]    qt;
  logic [CB-1:0]   qu;
  logic signed [CB-1:0] q_r;

  assign r3 = (HW+2)'(mh_r) - (((HW+2)'(qh_r)) << 1) - (HW+2)'(qh_r);
  assign t  = {r3[1:0], ml_r};
  assign pt = (2*K+4)'(t) * (2*K+4)'(MT3);
  assign qt = pt[2*K+2:K+3];
  assign qu = {qh_r, qt};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      neg_r <= neg;
      qh_r  <= ph[2*HW-1:HW+1];
      mh_r  <= m[MW-1:K];
      ml_r  <= m[K-1:0];
      q_r   <= neg_r ? $signed(-qu) : $signed(qu);
    end
  end

  assign q = q_r;

endmodule

/* src/cbz_seq.sv */
// Control point window, point count and per-segment result sequencer.
module cbz_seq #(
  parameter int CB = cbz_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [2:0][CB-1:0]        in_pt,
  input  logic                      in_fin,
  output logic                      in_stall,
  input  logic                      adv,
  output logic                      iss_valid,
  output cbz_pkg::tag_t             iss_tag,
  output cbz_pkg::wgt_t             iss_wgt,
  output logic [2:0][2:0][CB-1:0]   iss_ops   // [coord][slot]
);

  logic [2:0][2:0][CB-1:0] win_r;     // [slot][coord], slot 0 oldest
  logic [2:0]              cnt_r;
  logic                    job_v_r;
  logic [1:0]              idx_r;
  logic [2:0][2:0][CB-1:0] job_w_r;
  logic [2:0][CB-1:0]      job_p_r;
  logic                    first_r;
  logic                    fin_r;

  logic       acc, job_last, issue;
  logic [2:0] kind;

  assign acc      = in_valid & ~in_stall;
  assign job_last = fin_r ? (idx_r == 2'd3) : (idx_r == 2'd2);
  assign issue    = job_v_r & adv;
  assign in_stall = job_v_r & ~(adv & job_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      job_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      // a new segment starts when none is pending or on the last issue of the previous one
      if (acc && (cnt_r >= 3'd3)) begin
        job_v_r <= 1'b1;
        idx_r   <= 2'd0;
      end else if (issue) begin
        if (job_last) begin
          job_v_r <= 1'b0;
          idx_r   <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
      if (acc) begin
        if (in_fin) cnt_r <= 3'd0;
        else if (cnt_r < 3'd4) cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // window contents are only read once three points are held
  always_ff @(posedge clk) begin
    if (acc) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= in_pt;
      if (cnt_r >= 3'd3) begin
        job_w_r <= win_r;
        job_p_r <= in_pt;
        first_r <= (cnt_r == 3'd3);
        fin_r   <= in_fin;
      end
    end
  end

  always_comb begin
    case (idx_r)
      2'd0:    kind = first_r ? cbz_pkg::KIND_E_FIRST : cbz_pkg::KIND_E_INNER;
      2'd1:    kind = cbz_pkg::KIND_F;
      2'd2:    kind = cbz_pkg::KIND_G;
      2'd3:    kind = cbz_pkg::KIND_Z;
      default: kind = cbz_pkg::KIND_G;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (kind == cbz_pkg::KIND_Z) begin
        iss_ops[c][0] = job_w_r[1][c];
        iss_ops[c][1] = job_w_r[2][c];
        iss_ops[c][2] = job_p_r[c];
      end else begin
        iss_ops[c][0] = job_w_r[0][c];
        iss_ops[c][1] = job_w_r[1][c];
        iss_ops[c][2] = job_w_r[2][c];
      end
    end
  end

  always_comb begin
    iss_tag.curve_end = (kind == cbz_pkg::KIND_Z);
    iss_tag.run_last  = (kind == cbz_pkg::KIND_Z) | ((kind == cbz_pkg::KIND_G) & ~fin_r);
    case (kind)
      cbz_pkg::KIND_F: iss_tag.role = cbz_pkg::ROLE_INNER1;
      cbz_pkg::KIND_G: iss_tag.role = cbz_pkg::ROLE_INNER2;
      default:         iss_tag.role = cbz_pkg::ROLE_JUNC;
    endcase
  end

  assign iss_wgt   = cbz_pkg::kind_wgt(kind);
  assign iss_valid = job_v_r;

endmodule

/* src/cubic_bspline_to_bezier.sv */
// Top level: uniform cubic B-spline control points in, Bezier points out.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid, in_stall  | in_point_x/y/z, in_final_point
//  out     | out_valid, out_stall| out_x/y/z, out_role, out_run_last, out_curve_end
//
// One Bezier point leaves per cycle while the output is not stalled; a control
// point that completes a segment issues three results (four on the final point),
// and further points are stalled until the last of them issues. Each result is
// registered after the sum, after the divide of the high half and after the divide
// of the low half, all stages halting together while a valid output is stalled.
// Synchronous reset clears the point count, the pending segment and stage valids.
module cubic_bspline_to_bezier #(
  parameter int COORD_BITS = cbz_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic                         in_final_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic [1:0]                   out_role,
  output logic                         out_run_last,
  output logic                         out_curve_end
);

  localparam int CB = COORD_BITS;

  logic                    adv, iss_valid;
  logic [2:0][CB-1:0]      in_pt;
  cbz_pkg::tag_t           iss_tag, t1_r, t2_r, t3_r;
  cbz_pkg::wgt_t           iss_wgt;
  logic [2:0][2:0][CB-1:0] iss_ops;
  logic [2:0][CB-1:0]      q;
  logic                    v1_r, v2_r, v3_r;

  assign in_pt = {in_point_z, in_point_y, in_point_x};
  assign adv   = ~(v3_r & out_stall);

  cbz_seq #(.CB(CB)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_pt    (in_pt),
    .in_fin   (in_final_point),
    .in_stall (in_stall),
    .adv      (adv),
    .iss_valid(iss_valid),
    .iss_tag  (iss_tag),
    .iss_wgt  (iss_wgt),
    .iss_ops  (iss_ops)
  );

  for (genvar c = 0; c < 3; c++) begin : g_coord
    cbz_coord #(.CB(CB)) u_coord (
      .clk(clk),
      .en (adv),
      .x0 ($signed(iss_ops[c][0])),
      .x1 ($signed(iss_ops[c][1])),
      .x2 ($signed(iss_ops[c][2])),
      .wgt(iss_wgt),
      .q  (q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= iss_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r <= iss_tag;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  assign out_valid     = v3_r;
  assign out_x         = $signed(q[0]);
  assign out_y         = $signed(q[1]);
  assign out_z         = $signed(q[2]);
  assign out_role      = t3_r.role;
  assign out_run_last  = t3_r.run_last;
  assign out_curve_end = t3_r.curve_end;

  // final junction always closes the run and is a junction point
  a_end_junc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_curve_end |-> out_run_last && (out_role == cbz_pkg::ROLE_JUNC))
    else $error("curve end on a non-closing result");

  // requests are refused only while a segment is still being issued
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !iss_valid |-> !in_stall)
    else $error("input stalled with no pending segment");

  // an accepted first inner point is always followed by a second inner point
  a_role_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_role == cbz_pkg::ROLE_INNER1) |=>
      !out_valid || (out_role == cbz_pkg::ROLE_INNER2))
    else $error("inner points out of order");

endmodule
